// ===== src/nnfd_pkg.sv =====
// Shared constants, codes and types of the nearest-neighbor fit downscaler.
package nnfd_pkg;

   localparam int SIDE_W     = 13;            // sizes and output indices
   localparam int POS_W      = 12;            // input column and row counters
   localparam int PIX_W      = 8;             // one color channel
   localparam int MAX_SIDE   = 4096;
   localparam int ACC_W      = SIDE_W + 1;    // source index accumulators
   localparam int DEN_W      = SIDE_W + 1;    // divisor and remainder
   localparam int DIV_NUM_W  = 2 * SIDE_W;    // 2*side*md + mi fits in 26 bits
   localparam int DIV_STEPS  = DIV_NUM_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;

   localparam int REQ_DATA_W = 3 * PIX_W;
   localparam int RSP_FIELDS = 3 * PIX_W + 2 * SIDE_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_FIELDS;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DIMENSION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_WIDTH      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IN_HEIGHT     = 2'd2;

   // setup divisions
   localparam logic [OP_W-1:0] OP_OUT_WIDTH    = 2'd0;
   localparam logic [OP_W-1:0] OP_OUT_HEIGHT   = 2'd1;
   localparam logic [OP_W-1:0] OP_FIRST_SOURCE = 2'd2;
   localparam logic [OP_W-1:0] OP_SOURCE_STEP  = 2'd3;

   typedef struct packed {
      logic            latch_cfg;
      logic            load_div;
      logic            div_step;
      logic            store;
      logic [OP_W-1:0] op;
      logic            start_frame;
      logic            run;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cfg_write;
      logic scaling;
   } dp_status_type;

   typedef struct packed {
      logic [ACC_W-1:0] q;
      logic [DEN_W-1:0] r;
   } acc_type;

   // 0 counts as 1, above MAX_SIDE counts as MAX_SIDE
   function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] res;
      res = v;
      if (v == '0) begin
         res = SIDE_W'(1);
      end else if (v > SIDE_W'(MAX_SIDE)) begin
         res = SIDE_W'(MAX_SIDE);
      end
      return res;
   endfunction

endpackage

// ===== src/nnfd_divider.sv =====
// Restoring divider, one quotient bit per step, shared by all setup divisions.
module nnfd_divider import nnfd_pkg::*; (
   input  logic                 clock,
   input  logic                 start,
   input  logic                 step,
   input  logic [DIV_NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0]     denominator,
   output logic [DIV_NUM_W-1:0] quotient,
   output logic [DEN_W-1:0]     remainder
);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff;
   logic [DEN_W:0]       trial;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
      rem_in = trial[DEN_W-1:0];
      if (trial >= {1'b0, den_ff}) begin
         rem_in = DEN_W'(trial - {1'b0, den_ff});
         quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numerator;
         rem_ff <= '0;
         den_ff <= denominator;
      end else if (step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/nnfd_controller.sv =====
// Sequencer: frame setup divisions, then pixel streaming.
module nnfd_controller import nnfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [2:0] ST_SETUP  = 3'd0;
   localparam logic [2:0] ST_PREP   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_STORE  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;
   localparam logic [2:0] ST_RUN    = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      cmd      = '0;
      cmd.op   = op_ff;
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_SETUP: begin
            cmd.latch_cfg = 1'b1;
            op_in         = OP_OUT_WIDTH;
            state_in      = ST_PREP;
         end
         ST_PREP: begin
            if (!status.scaling) begin
               state_in = ST_FINISH;
            end else begin
               cmd.load_div = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (op_ff == OP_SOURCE_STEP) begin
               state_in = ST_FINISH;
            end else begin
               op_in    = op_ff + OP_W'(1);
               state_in = ST_PREP;
            end
         end
         ST_FINISH: begin
            cmd.start_frame = 1'b1;
            state_in        = ST_RUN;
         end
         ST_RUN: begin
            cmd.run = 1'b1;
         end
         default: begin
            state_in = ST_SETUP;
         end
      endcase
      // a register write aborts the frame and redoes the setup
      if (status.cfg_write) begin
         state_in = ST_SETUP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SETUP;
         op_ff    <= OP_OUT_WIDTH;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== src/nnfd_datapath.sv =====
// Registers, setup arithmetic, source index tracking and output stage.
module nnfd_datapath import nnfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIDE_W-1:0]     csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status
);

   // configuration registers
   logic [SIDE_W-1:0] md_cfg_ff, w_cfg_ff, h_cfg_ff;
   // latched frame geometry
   logic [SIDE_W-1:0] eff_w_ff, eff_h_ff, mi_ff, md_ff;
   logic              scaling_ff;
   logic [SIDE_W-1:0] fw_ff, fh_ff;
   logic [SIDE_W-1:0] q0_ff, qs_ff;
   logic [DEN_W-1:0]  r0_ff, rs_ff, den_ff;
   // frame position
   logic [POS_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [SIDE_W-1:0] oc_ff, oc_in, orow_ff, orow_in;
   logic [SIDE_W-1:0] nsc_ff, nsc_in, nsr_ff, nsr_in;
   acc_type           cacc_ff, cacc_in, racc_ff, racc_in;
   // output stage
   logic              rsp_valid_ff, rsp_last_ff;
   logic [PIX_W-1:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [SIDE_W-1:0] rsp_w_ff, rsp_h_ff;

   logic [SIDE_W-1:0]    ew, eh, emi;
   logic                 escaling;
   logic [SIDE_W-1:0]    w_m1, h_m1;
   logic                 accept, hit, emit_last;
   acc_type              cadv, radv, acc0;
   logic [DIV_NUM_W-1:0] div_num, div_quo;
   logic [DEN_W-1:0]     div_den, div_rem;
   logic [DIV_NUM_W-1:0] num_wide;
   logic [SIDE_W-1:0]    quo_side;

   function automatic acc_type advance(input acc_type a,
                                       input logic [SIDE_W-1:0] qs,
                                       input logic [DEN_W-1:0] rs,
                                       input logic [DEN_W-1:0] den);
      logic [DEN_W:0] rsum;
      acc_type        res;
      rsum  = {1'b0, a.r} + {1'b0, rs};
      res.q = a.q + {1'b0, qs};
      res.r = rsum[DEN_W-1:0];
      if (rsum >= {1'b0, den}) begin
         res.q = res.q + ACC_W'(1);
         res.r = DEN_W'(rsum - {1'b0, den});
      end
      return res;
   endfunction

   function automatic logic [SIDE_W-1:0] clamp(input logic [ACC_W-1:0] q,
                                                input logic [SIDE_W-1:0] lim);
      logic [SIDE_W-1:0] res;
      res = q[SIDE_W-1:0];
      if (q > {1'b0, lim}) begin
         res = lim;
      end
      return res;
   endfunction

   // ---- configuration ----
   always_comb begin
      status.cfg_write = 1'b0;
      case (csr_index)
         REG_MAX_DIMENSION, REG_IN_WIDTH, REG_IN_HEIGHT: status.cfg_write = csr_we;
         default: status.cfg_write = 1'b0;
      endcase
      status.scaling = scaling_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         md_cfg_ff <= '0;
         w_cfg_ff  <= SIDE_W'(1);
         h_cfg_ff  <= SIDE_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_MAX_DIMENSION: md_cfg_ff <= csr_wdata;
            REG_IN_WIDTH:      w_cfg_ff  <= csr_wdata;
            REG_IN_HEIGHT:     h_cfg_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- setup ----
   assign ew       = eff_side(w_cfg_ff);
   assign eh       = eff_side(h_cfg_ff);
   assign emi      = (ew > eh) ? ew : eh;
   assign escaling = (md_cfg_ff != '0) && (emi > md_cfg_ff);

   always_comb begin
      num_wide = DIV_NUM_W'((cmd.op == OP_OUT_WIDTH) ? eff_w_ff : eff_h_ff) *
                 DIV_NUM_W'(md_ff);
      div_num  = '0;
      div_den  = {md_ff, 1'b0};
      case (cmd.op)
         OP_OUT_WIDTH, OP_OUT_HEIGHT: begin
            // 2*side*md + mi over 2*mi, rounds to nearest
            div_num = DIV_NUM_W'({num_wide, 1'b0} + (DIV_NUM_W + 1)'(mi_ff));
            div_den = {mi_ff, 1'b0};
         end
         OP_FIRST_SOURCE: div_num = DIV_NUM_W'(mi_ff);
         OP_SOURCE_STEP:  div_num = DIV_NUM_W'({mi_ff, 1'b0});
         default:         div_num = '0;
      endcase
   end

   nnfd_divider u_divider (
      .clock       (clock),
      .start       (cmd.load_div),
      .step        (cmd.div_step),
      .numerator   (div_num),
      .denominator (div_den),
      .quotient    (div_quo),
      .remainder   (div_rem)
   );

   assign quo_side = (div_quo == '0) ? SIDE_W'(1) : div_quo[SIDE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.latch_cfg) begin
         eff_w_ff   <= ew;
         eff_h_ff   <= eh;
         mi_ff      <= emi;
         md_ff      <= md_cfg_ff;
         scaling_ff <= escaling;
         // pass-through values, replaced by the divisions when scaling
         fw_ff      <= ew;
         fh_ff      <= eh;
         q0_ff      <= '0;
         r0_ff      <= '0;
         qs_ff      <= SIDE_W'(1);
         rs_ff      <= '0;
         den_ff     <= escaling ? {md_cfg_ff, 1'b0} : DEN_W'(1);
      end else if (cmd.store) begin
         case (cmd.op)
            OP_OUT_WIDTH:  fw_ff <= quo_side;
            OP_OUT_HEIGHT: fh_ff <= quo_side;
            OP_FIRST_SOURCE: begin
               q0_ff <= div_quo[SIDE_W-1:0];
               r0_ff <= div_rem;
            end
            OP_SOURCE_STEP: begin
               qs_ff <= div_quo[SIDE_W-1:0];
               rs_ff <= div_rem;
            end
            default: ;
         endcase
      end
   end

   // ---- pixel stream ----
   assign w_m1       = eff_w_ff - SIDE_W'(1);
   assign h_m1       = eff_h_ff - SIDE_W'(1);
   assign req_tready = cmd.run && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign acc0.q     = {1'b0, q0_ff};
   assign acc0.r     = r0_ff;
   assign cadv       = advance(cacc_ff, qs_ff, rs_ff, den_ff);
   assign radv       = advance(racc_ff, qs_ff, rs_ff, den_ff);
   assign hit        = ({1'b0, col_ff} == nsc_ff) && ({1'b0, row_ff} == nsr_ff) &&
                       (oc_ff < fw_ff) && (orow_ff < fh_ff);
   assign emit_last  = (oc_ff == fw_ff - SIDE_W'(1)) && (orow_ff == fh_ff - SIDE_W'(1));

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      oc_in   = oc_ff;
      orow_in = orow_ff;
      nsc_in  = nsc_ff;
      nsr_in  = nsr_ff;
      cacc_in = cacc_ff;
      racc_in = racc_ff;
      if (accept) begin
         if (hit) begin
            oc_in = oc_ff + SIDE_W'(1);
            if (oc_ff + SIDE_W'(1) < fw_ff) begin
               cacc_in = cadv;
               nsc_in  = clamp(cadv.q, w_m1);
            end
         end
         if ({1'b0, col_ff} >= w_m1) begin
            // end of line: move to the next output row if this one was used
            if (({1'b0, row_ff} == nsr_ff) && (orow_ff < fh_ff)) begin
               orow_in = orow_ff + SIDE_W'(1);
               oc_in   = '0;
               cacc_in = acc0;
               nsc_in  = clamp(acc0.q, w_m1);
               if (orow_ff + SIDE_W'(1) < fh_ff) begin
                  racc_in = radv;
                  nsr_in  = clamp(radv.q, h_m1);
               end
            end
            col_in = '0;
            if ({1'b0, row_ff} >= h_m1) begin
               row_in  = '0;
               oc_in   = '0;
               orow_in = '0;
               cacc_in = acc0;
               racc_in = acc0;
               nsc_in  = clamp(acc0.q, w_m1);
               nsr_in  = clamp(acc0.q, h_m1);
            end else begin
               row_in = row_ff + POS_W'(1);
            end
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
      if (cmd.start_frame) begin
         col_in  = '0;
         row_in  = '0;
         oc_in   = '0;
         orow_in = '0;
         cacc_in = acc0;
         racc_in = acc0;
         nsc_in  = clamp(acc0.q, w_m1);
         nsr_in  = clamp(acc0.q, h_m1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         oc_ff   <= '0;
         orow_ff <= '0;
         nsc_ff  <= '0;
         nsr_ff  <= '0;
         cacc_ff <= '0;
         racc_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         oc_ff   <= oc_in;
         orow_ff <= orow_in;
         nsc_ff  <= nsc_in;
         nsr_ff  <= nsr_in;
         cacc_ff <= cacc_in;
         racc_ff <= racc_in;
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && hit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hit) begin
         rsp_red_ff   <= req_tdata[PIX_W-1:0];
         rsp_green_ff <= req_tdata[2*PIX_W-1:PIX_W];
         rsp_blue_ff  <= req_tdata[3*PIX_W-1:2*PIX_W];
         rsp_last_ff  <= emit_last;
         rsp_w_ff     <= fw_ff;
         rsp_h_ff     <= fh_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_h_ff, rsp_w_ff,
                        rsp_blue_ff, rsp_green_ff, rsp_red_ff};

endmodule

// ===== src/nearest_neighbor_fit_downscaler_unit.sv =====
// Top level of the nearest-neighbor fit downscaler: controller plus datapath.
// A selected pixel is registered and appears on rsp in the cycle after its req transaction.
// Throughput: one pixel per cycle while streaming; rsp backpressure stalls req.
// Setup: after reset or any write to a real register, req_tready stays low until
// the setup is done (scaling: four 26-step divisions on one divider).
// Reset is synchronous, active high; registers return to md=0, width=height=1.
module nearest_neighbor_fit_downscaler_unit import nnfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SIDE_W-1:0]     csr_wdata,
   // input pixels
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // red, green, blue
   // output pixels
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_red, out_green, out_blue,
                                              // out_width, out_height, zero pad
   output logic                  rsp_tlast    // frame_end
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer: setup (with divisions when scaling) on each register write, then streams.
   nnfd_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Output sizes are rounded to nearest; source indices advance by an
   // exact quotient/remainder step, so no per-pixel divide is needed.
   nnfd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ===== test/nearest_neighbor_fit_downscaler_unit_tb.sv =====
// Self-checking testbench for the nearest-neighbor fit downscaler against a predictor.
module nearest_neighbor_fit_downscaler_unit_tb;
   import nnfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // index with no register behind it; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 4;       // the result is registered, keep some margin
   localparam int TAIL_CYCLES   = 8;
   localparam int RANDOM_PIXELS = 600;
   localparam int CALM_PIXELS   = 100;     // last stretch runs with no gaps and no stalls
   localparam int MAX_REPORTS   = 10;
   localparam int CYCLE_LIMIT   = 1000000;

   // one output pixel with its frame info
   typedef struct packed {
      logic [PIX_W-1:0]  red;
      logic [PIX_W-1:0]  green;
      logic [PIX_W-1:0]  blue;
      logic              frame_end;
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
   } pixel_result_type;

   // Tracks the downscaler's frame state and queues the pixels it must emit.
   class downscale_scoreboard_type;
      logic [SIDE_W-1:0] max_dimension;
      logic [SIDE_W-1:0] in_width;
      logic [SIDE_W-1:0] in_height;
      logic [POS_W-1:0]  column_count;
      logic [POS_W-1:0]  row_count;
      logic [SIDE_W-1:0] out_column;
      logic [SIDE_W-1:0] out_row;
      logic [SIDE_W-1:0] next_column;
      logic [SIDE_W-1:0] next_row;
      logic [SIDE_W-1:0] out_width;
      logic [SIDE_W-1:0] out_height;
      pixel_result_type  expected_pixels[$];
      int                mismatches;

      function new();
         max_dimension = '0;
         in_width      = SIDE_W'(1);
         in_height     = SIDE_W'(1);
         mismatches    = 0;
         restart_frame();
      endfunction

      // 0 reads as 1, anything above MAX_SIDE as MAX_SIDE
      function longint unsigned side_of(logic [SIDE_W-1:0] v);
         longint unsigned s;
         s = 64'(v);
         if (s == 0) begin
            s = 1;
         end else if (s > MAX_SIDE) begin
            s = MAX_SIDE;
         end
         return s;
      endfunction

      function longint unsigned longest_side();
         longint unsigned w;
         longint unsigned h;
         w = side_of(in_width);
         h = side_of(in_height);
         return (w > h) ? w : h;
      endfunction

      function bit downscaling();
         return (max_dimension != '0) && (longest_side() > 64'(max_dimension));
      endfunction

      // source index of output index k, half-pixel centered, clamped to the side
      function logic [SIDE_W-1:0] source_of(longint unsigned k, longint unsigned side);
         longint unsigned s;
         longint unsigned md;
         s  = k;
         md = 64'(max_dimension);
         if (downscaling()) begin
            s = ((2 * k + 1) * longest_side()) / (2 * md);
         end
         if (s > side - 1) begin
            s = side - 1;
         end
         return SIDE_W'(s);
      endfunction

      // rounded fitted side, never below 1
      function logic [SIDE_W-1:0] fitted_side(longint unsigned side);
         longint unsigned md;
         longint unsigned mi;
         longint unsigned r;
         r = side;
         if (downscaling()) begin
            md = 64'(max_dimension);
            mi = longest_side();
            r  = (2 * side * md + mi) / (2 * mi);
            if (r < 1) begin
               r = 1;
            end
         end
         return SIDE_W'(r);
      endfunction

      function void restart_frame();
         column_count = '0;
         row_count    = '0;
         out_column   = '0;
         out_row      = '0;
         out_width    = fitted_side(side_of(in_width));
         out_height   = fitted_side(side_of(in_height));
         next_column  = source_of(0, side_of(in_width));
         next_row     = source_of(0, side_of(in_height));
      endfunction

      // any write to a real register aborts the frame in flight
      function void write_register(logic [CSR_IDX_W-1:0] index, logic [SIDE_W-1:0] value);
         case (index)
            REG_MAX_DIMENSION: max_dimension = value;
            REG_IN_WIDTH:      in_width      = value;
            REG_IN_HEIGHT:     in_height     = value;
            default:           return;
         endcase
         restart_frame();
      endfunction

      function void note_pixel(logic [REQ_DATA_W-1:0] pix);
         longint unsigned  w;
         longint unsigned  h;
         pixel_result_type want;
         w = side_of(in_width);
         h = side_of(in_height);
         if ({1'b0, row_count} == next_row && {1'b0, column_count} == next_column &&
             out_column < out_width && out_row < out_height) begin
            want.red       = pix[0 +: PIX_W];
            want.green     = pix[PIX_W +: PIX_W];
            want.blue      = pix[2 * PIX_W +: PIX_W];
            want.frame_end = (out_column == out_width - SIDE_W'(1)) &&
                             (out_row == out_height - SIDE_W'(1));
            want.width     = out_width;
            want.height    = out_height;
            expected_pixels.push_back(want);
            out_column++;
            if (out_column < out_width) begin
               next_column = source_of(64'(out_column), w);
            end
         end
         if (64'(column_count) >= w - 1) begin
            // end of an input row: advance the output row if this one was sampled
            if ({1'b0, row_count} == next_row && out_row < out_height) begin
               out_row++;
               out_column  = '0;
               next_column = source_of(0, w);
               if (out_row < out_height) begin
                  next_row = source_of(64'(out_row), h);
               end
            end
            column_count = '0;
            if (64'(row_count) >= h - 1) begin
               restart_frame();
            end else begin
               row_count++;
            end
         end else begin
            column_count++;
         end
      endfunction

      function void check_pixel(logic [RSP_DATA_W-1:0] data, logic last);
         pixel_result_type got;
         pixel_result_type want;
         got.red       = data[0 +: PIX_W];
         got.green     = data[PIX_W +: PIX_W];
         got.blue      = data[2 * PIX_W +: PIX_W];
         got.frame_end = last;
         got.width     = data[3 * PIX_W +: SIDE_W];
         got.height    = data[3 * PIX_W + SIDE_W +: SIDE_W];
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected pixel rgb=%h,%h,%h last=%0b size=%0dx%0d", got.red,
                        got.green, got.blue, got.frame_end, got.width, got.height);
            end
            return;
         end
         want = expected_pixels.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("pixel mismatch: expected rgb=%h,%h,%h last=%0b size=%0dx%0d",
                        want.red, want.green, want.blue, want.frame_end, want.width,
                        want.height);
               $display("                actual   rgb=%h,%h,%h last=%0b size=%0dx%0d",
                        got.red, got.green, got.blue, got.frame_end, got.width, got.height);
            end
         end
      endfunction

      function void close();
         if (expected_pixels.size() != 0) begin
            $display("%0d expected pixels never arrived", expected_pixels.size());
            mismatches += expected_pixels.size();
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [SIDE_W-1:0]     csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // red, green, blue
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // out_red, out_green, out_blue,
                                             // out_width, out_height, zero pad
   logic                  rsp_tlast;         // frame_end

   bit                    req_gaps_on   = 1'b1;
   bit                    rsp_stalls_on = 1'b1;
   int unsigned           cycle_count   = 0;

   downscale_scoreboard_type scoreboard = new();

   nearest_neighbor_fit_downscaler_unit uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Everything is sampled at the rising edge; the bench drives with nonblocking
   // assignments and the block updates its outputs the same way, so all values
   // read here are the ones that were present at the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            scoreboard.write_register(csr_index, csr_wdata);
         end
         // input first: a pixel cannot come out before the transaction that carries it
         if (req_tvalid && req_tready) begin
            scoreboard.note_pixel(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            scoreboard.check_pixel(rsp_tdata, rsp_tlast);
         end
      end
   end

   // Output backpressure: rsp_tready is dropped in random stall bursts.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog. A correct run stays well below CYCLE_LIMIT even in the worst
   // case: several hundred phases of a single pixel, each with a few register
   // writes, a full setup, an input gap and an output stall.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // Offers one pixel and holds it until the transaction completes. An optional
   // gap with valid low goes first. Valid stays high between back-to-back
   // pixels, so it is never lowered and raised in the same step.
   task automatic send_pixel(input logic [REQ_DATA_W-1:0] pix);
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops input and waits until every predicted pixel has come out, then a
   // settling wait of SETTLE_CYCLES for a last pixel that produced nothing.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (scoreboard.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes only go in with the block idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [SIDE_W-1:0] value);
      drain_pipeline();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly small sides (and limits below them, so scaling kicks in); now and
   // then a corner value: 0, 1, right at and around MAX_SIDE, all ones.
   function automatic logic [SIDE_W-1:0] pick_register_value(input bit is_limit);
      logic [SIDE_W-1:0] v;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 5))
               0:       v = SIDE_W'(0);
               1:       v = SIDE_W'(1);
               2:       v = SIDE_W'(MAX_SIDE - 1);
               3:       v = SIDE_W'(MAX_SIDE);
               4:       v = SIDE_W'(MAX_SIDE + 1);
               default: v = '1;
            endcase
         end
         1:       v = is_limit ? '0 : SIDE_W'($urandom_range(1, 12));
         default: v = SIDE_W'($urandom_range(1, is_limit ? 10 : 12));
      endcase
      return v;
   endfunction

   initial begin
      int random_pixels;
      int phase_pixels;
      longint unsigned frame_pixels;
      bit wrote;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // reset settings: 1x1 frames, no resizing, every pixel is its own frame end
      send_pixel('0);
      send_pixel('1);

      // 4x2 fitted to 2: output 2x1, taken from columns 1 and 3 of the bottom row
      write_csr(REG_MAX_DIMENSION, SIDE_W'(2));
      write_csr(REG_IN_WIDTH, SIDE_W'(4));
      write_csr(REG_IN_HEIGHT, SIDE_W'(2));
      send_pixel(24'hAA55AA);
      send_pixel(24'h55AA55);
      repeat (6) send_pixel(REQ_DATA_W'($urandom));

      // zero width reads as 1, all-ones height as MAX_SIDE; a limit equal to the
      // longest side means the frame already fits and passes through
      write_csr(REG_IN_WIDTH, '0);
      write_csr(REG_IN_HEIGHT, '1);
      write_csr(REG_MAX_DIMENSION, SIDE_W'(MAX_SIDE));
      repeat (3) send_pixel(REQ_DATA_W'($urandom));

      // write to the unused index in mid-frame: the frame carries on
      write_csr(REG_UNUSED, '1);
      repeat (2) send_pixel(REQ_DATA_W'($urandom));

      // 5x1 fitted to 1: only the middle pixel survives
      write_csr(REG_MAX_DIMENSION, SIDE_W'(1));
      write_csr(REG_IN_WIDTH, SIDE_W'(5));
      write_csr(REG_IN_HEIGHT, SIDE_W'(1));
      repeat (5) send_pixel(REQ_DATA_W'($urandom));

      // widest frame, limit one below it: scaling that keeps nearly every pixel
      write_csr(REG_MAX_DIMENSION, SIDE_W'(MAX_SIDE - 1));
      write_csr(REG_IN_WIDTH, SIDE_W'(MAX_SIDE));
      repeat (3) send_pixel(REQ_DATA_W'($urandom));

      // --- random phases ---
      // Each phase rewrites some registers (aborting the frame), then streams one
      // to three whole frames plus a few extra pixels so frames wrap and are also
      // cut off partway. Long frames are capped so the run stays short.
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         if (random_pixels >= RANDOM_PIXELS - CALM_PIXELS) begin
            req_gaps_on   = 1'b0;
            rsp_stalls_on = 1'b0;
         end else begin
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
         end
         wrote = 1'b0;
         while (!wrote) begin
            if ($urandom_range(0, 1)) begin
               write_csr(REG_MAX_DIMENSION, pick_register_value(1'b1));
               wrote = 1'b1;
            end
            if ($urandom_range(0, 1)) begin
               write_csr(REG_IN_WIDTH, pick_register_value(1'b0));
               wrote = 1'b1;
            end
            if ($urandom_range(0, 1)) begin
               write_csr(REG_IN_HEIGHT, pick_register_value(1'b0));
               wrote = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
               write_csr(REG_UNUSED, SIDE_W'($urandom_range(0, 8191)));
            end
         end
         frame_pixels = scoreboard.side_of(scoreboard.in_width) *
                        scoreboard.side_of(scoreboard.in_height);
         phase_pixels = int'(frame_pixels) * $urandom_range(1, 3) + $urandom_range(0, 2);
         if (frame_pixels > 40 || phase_pixels > 120) begin
            phase_pixels = $urandom_range(40, 120);
         end
         repeat (phase_pixels) send_pixel(REQ_DATA_W'($urandom));
         random_pixels += phase_pixels;
      end

      // --- wrap up ---
      drain_pipeline();
      repeat (TAIL_CYCLES) @(posedge clock);
      scoreboard.close();
      if (scoreboard.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
